FILE: rtl/bmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmls_pkg: shared constants for the byte memory load/store unit
// Store size, lane layout, fill pattern and access codes.
// ----------------------------------------------------------------------------
package bmls_pkg;

    // Requested store size in bytes; the store is rounded up to a multiple of 16 bytes.
    localparam int unsigned MEM_BYTES = 65536;
    localparam logic [31:0] MEM_SIZE  = (32'(MEM_BYTES) + 32'd15) & 32'hFFFF_FFF0;

    // Four byte lanes, lane = address[1:0], row = address >> 2.
    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned LANE_W    = 2;
    localparam int unsigned NUM_ROWS  = MEM_SIZE / NUM_LANES;
    localparam int unsigned ROW_W     = $clog2(NUM_ROWS);

    localparam logic [7:0] FILL_BYTE = 8'hA5;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

endpackage

FILE: rtl/byte_memory_load_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_memory_load_store_unit: little-endian byte-addressable memory port
// One read or write of 1, 2 or 4 bytes per transaction, any alignment.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) takes one access per transaction: tuser carries
//   op, access size and sign-extend flag, tdata the address and write data.
//   Master channel (m_axis_*) returns exactly one result per access: tdata is
//   the assembled read value (zero for writes), tuser the out-of-range flag.
//   The store is four byte-wide lane memories (lane = address bits 1:0), so
//   an unaligned access touches each lane at most once; one registered read
//   port per lane sets the timing.
//   Path: the access is read into the read stage at the accepting edge, then
//   moves to the output register that drives m_axis_tvalid. Throughput: one
//   transaction per cycle while the master side keeps tready high.
//   Writes land in the store at the accepting edge, so a following read sees
//   them.
//   Reset: after rst_n releases, a fill pass writes 0xA5 to one row of all
//   four lanes per cycle through all NUM_ROWS rows (16384 for a 64 KiB
//   store); tready stays low until it ends.
//   Stall: with master tready low, one result waits in the output register
//   and one in the read stage; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module byte_memory_load_store_unit
    import bmls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] address, [63:32] write_data
    input  logic [3:0]  s_axis_tuser,  // [0] op, [2:1] access_size, [3] sign_extend
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] read_data
    output logic [0:0]  m_axis_tuser   // [0] out_of_range
);

    // input fields
    logic        in_op;
    logic [1:0]  in_size;
    logic        in_sx;
    logic [31:0] in_addr;
    logic [31:0] in_wdata;
    logic        accept;

    assign in_op    = s_axis_tuser[0];
    assign in_size  = s_axis_tuser[2:1];
    assign in_sx    = s_axis_tuser[3];
    assign in_addr  = s_axis_tdata[31:0];
    assign in_wdata = s_axis_tdata[63:32];

    // fill pass
    logic             clearing_reg;
    logic [ROW_W-1:0] clr_row_reg;

    // read stage
    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    logic [1:0]           s1_size_reg;
    logic                 s1_sx_reg;
    logic [LANE_W-1:0]    s1_base_reg;
    logic [NUM_LANES-1:0] s1_mask_reg;
    logic                 s1_oor_reg;
    logic [7:0]           rd_reg [NUM_LANES];

    // output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_oor_reg;
    logic        out_op_reg;
    logic        out_ready;

    // per-lane request decode
    logic [LANE_W-1:0]    lane_k    [NUM_LANES];
    logic [31:0]          lane_addr [NUM_LANES];
    logic [ROW_W-1:0]     lane_row  [NUM_LANES];
    logic [7:0]           lane_wbyte[NUM_LANES];
    logic [NUM_LANES-1:0] lane_act;
    logic [NUM_LANES-1:0] lane_ok;
    logic                 req_oor;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || out_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        req_oor = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // byte index within the access that falls on this lane
            lane_k[l]    = LANE_W'(l) - in_addr[LANE_W-1:0];
            lane_addr[l] = in_addr + 32'(lane_k[l]);
            lane_row[l]  = lane_addr[l][ROW_W+LANE_W-1:LANE_W];
            lane_wbyte[l] = in_wdata[8*lane_k[l] +: 8];
            case (in_size)
                SIZE_BYTE: lane_act[l] = (lane_k[l] == '0);
                SIZE_HALF: lane_act[l] = !lane_k[l][1];
                default:   lane_act[l] = 1'b1;
            endcase
            lane_ok[l] = lane_act[l] && (lane_addr[l] < MEM_SIZE);
            if (lane_act[l] && !lane_ok[l])
            begin
                req_oor = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            logic [7:0] mem [NUM_ROWS];

            always_ff @(posedge clk)
            begin
                if (clearing_reg)
                begin
                    mem[clr_row_reg] <= FILL_BYTE;
                end
                else if (accept && in_op == OP_WRITE && lane_ok[g])
                begin
                    mem[lane_row[g]] <= lane_wbyte[g];
                end
                if (accept)
                begin
                    rd_reg[g] <= mem[lane_row[g]];
                end
            end
        end
    endgenerate

    // assemble the little-endian read value
    logic [7:0]  asm_byte [NUM_LANES];
    logic [31:0] asm_data;
    logic [31:0] res_data;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            asm_byte[k] = s1_mask_reg[s1_base_reg + LANE_W'(k)]
                          ? rd_reg[s1_base_reg + LANE_W'(k)] : 8'h00;
        end
        asm_data = {asm_byte[3], asm_byte[2], asm_byte[1], asm_byte[0]};
        res_data = asm_data;
        if (s1_sx_reg)
        begin
            if (s1_size_reg == SIZE_BYTE && asm_data[7])
            begin
                res_data = asm_data | 32'hFFFF_FF00;
            end
            else if (s1_size_reg == SIZE_HALF && asm_data[15])
            begin
                res_data = asm_data | 32'hFFFF_0000;
            end
        end
        if (s1_op_reg == OP_WRITE)
        begin
            res_data = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(NUM_ROWS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= in_op;
            s1_size_reg <= in_size;
            s1_sx_reg   <= in_sx;
            s1_base_reg <= in_addr[LANE_W-1:0];
            s1_mask_reg <= (in_op == OP_READ) ? lane_ok : '0;
            s1_oor_reg  <= req_oor;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_data_reg <= res_data;
            out_oor_reg  <= s1_oor_reg;
            out_op_reg   <= s1_op_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_oor_reg;

`ifndef NO_ASSERTIONS
    // nothing enters during the fill pass
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("transaction accepted during fill pass");

    // a result in the read stage moves to the output when it has room
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("read stage result lost");

    // write results carry zero data
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_op_reg == OP_WRITE) |-> (out_data_reg == 32'h0))
        else $error("write result with nonzero data");

    // an accepted item is always in the read stage next cycle
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction missing from read stage");
`endif

endmodule
